// ===== hw/rtl/ttab_pkg.sv =====
package ttab_pkg;

    // Bucket count; the index is the low bits of the hash, so this stays a power of two.
    localparam int BUCKETS = 4096;
    localparam int IDX_W   = $clog2(BUCKETS);

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 32;

    localparam int LANE_ONE = 0;
    localparam int LANE_TWO = 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_PROBE  = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [SCORE_W-1:0] score;
        logic signed [DEPTH_W-1:0] depth;
        logic [KEY_W-1:0]          key;
    } lane_t;

    typedef struct packed {
        lane_t      second;
        lane_t      first;
        logic [1:0] valid;
    } bucket_t;

    localparam int BUCKET_W = $bits(bucket_t);

    typedef struct packed {
        cmd_t                      cmd;
        logic [KEY_W-1:0]          key;
        logic signed [DEPTH_W-1:0] depth;
        logic signed [SCORE_W-1:0] score;
        logic [KIND_W-1:0]         kind;
    } item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch input beat, issue bucket read
        logic wr_en;     // write back updated bucket
        logic wipe;      // write an empty bucket at the sweep address
        logic out_load;  // load the result register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t item_cmd;
        logic wipe_last;
        logic out_busy;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/ttab_ram.sv =====
module ttab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/ttab_ctrl.sv =====
module ttab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ttab_pkg::ctl_sts_t sts,
    output ttab_pkg::ctl_cmd_t cmd
);
    import ttab_pkg::*;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (sts.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // bucket word is valid now; finish once the result slot is free
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.wr_en    = (sts.item_cmd == CMD_INSERT);
                    state_next   = (sts.item_cmd == CMD_CLEAR) ? ST_WIPE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_WIPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ttab_dp.sv =====
module ttab_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ttab_pkg::ctl_cmd_t cmd,
    output ttab_pkg::ctl_sts_t sts,
    input  logic [95:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [95:0]        m_tdata,
    output logic               m_tuser
);
    import ttab_pkg::*;

    item_t            item_reg;
    logic [IDX_W-1:0] wipe_cnt_reg;
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] misses_reg;
    logic [CNT_W-1:0] hits_next;
    logic [CNT_W-1:0] misses_next;
    logic             out_valid_reg;
    logic [95:0]      out_data_reg;
    logic             out_hit_reg;

    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_addr;
    logic [BUCKET_W-1:0] rd_word;
    bucket_t             bkt;
    bucket_t             upd;
    logic [BUCKET_W-1:0] wr_word;
    logic                hit_one;
    logic                hit_two;
    logic                hit;
    logic                fill_one;
    lane_t               found;
    lane_t               new_lane;

    assign rd_idx  = s_tdata[IDX_W-1:0];
    assign wr_addr = cmd.wipe ? wipe_cnt_reg : item_reg.key[IDX_W-1:0];
    assign wr_word = cmd.wipe ? '0 : upd;

    ttab_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (cmd.wr_en | cmd.wipe),
        .waddr (wr_addr),
        .wdata (wr_word),
        .re    (cmd.load),
        .raddr (rd_idx),
        .rdata (rd_word)
    );

    assign bkt = rd_word;

    always_comb
    begin
        hit_one  = bkt.valid[LANE_ONE] && (bkt.first.key == item_reg.key) &&
                   (bkt.first.depth >= item_reg.depth);
        hit_two  = bkt.valid[LANE_TWO] && (bkt.second.key == item_reg.key) &&
                   (bkt.second.depth >= item_reg.depth);
        hit      = (item_reg.cmd == CMD_PROBE) && (hit_one || hit_two);
        found    = hit_one ? bkt.first : bkt.second;
        fill_one = !bkt.valid[LANE_ONE] || (bkt.first.depth < item_reg.depth);

        new_lane.key   = item_reg.key;
        new_lane.depth = item_reg.depth;
        new_lane.score = item_reg.score;
        new_lane.kind  = item_reg.kind;

        upd = bkt;
        if (fill_one)
        begin
            upd.valid[LANE_ONE] = 1'b1;
            upd.first           = new_lane;
        end
        else
        begin
            upd.valid[LANE_TWO] = 1'b1;
            upd.second          = new_lane;
        end

        hits_next   = hits_reg;
        misses_next = misses_reg;
        case (item_reg.cmd)
            CMD_PROBE:
            begin
                if (hit)
                begin
                    hits_next = (hits_reg == COUNT_MAX) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_next = (misses_reg == COUNT_MAX) ? misses_reg : misses_reg + 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                hits_next   = '0;
                misses_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg.cmd   <= s_tuser;
            item_reg.key   <= s_tdata[63:0];
            item_reg.depth <= s_tdata[71:64];
            item_reg.score <= s_tdata[87:72];
            item_reg.kind  <= s_tdata[89:88];
        end
        if (cmd.out_load)
        begin
            out_hit_reg  <= hit;
            out_data_reg <= {6'd0, misses_next, hits_next,
                             hit ? found.kind  : {KIND_W{1'b0}},
                             hit ? found.score : {SCORE_W{1'b0}},
                             hit ? found.depth : {DEPTH_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_cnt_reg  <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wipe)
            begin
                wipe_cnt_reg <= wipe_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.item_cmd  = item_reg.cmd;
    assign sts.wipe_last = (wipe_cnt_reg == IDX_W'(BUCKETS - 1));
    assign sts.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

// ===== hw/rtl/two_way_depth_replace_hash_table.sv =====
// Two-lane hash table, 4096 buckets indexed by the low hash bits. Each input beat
// (probe, insert, clear) gives exactly one result beat. A probe or insert first
// reads the bucket from the bucket RAM (registered read), then, once the output
// register is free, compares, forms the result and (insert only) writes the bucket
// back. A clear gives its result beat, then sweeps the RAM to drop the valid bits,
// one bucket a cycle, with s_tready low until all buckets are wiped. The same sweep
// runs after reset before the first beat is taken. A finished result waits in the
// output register without blocking the next input beat.
module two_way_depth_replace_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] key_hash, [71:64] search_depth, [87:72] entry_score, [89:88] entry_kind
    input  logic [95:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] found_depth, [23:8] found_score, [25:24] found_kind,
    // [57:26] hits_total, [89:58] misses_total
    output logic [95:0] m_tdata,
    // [0] hit
    output logic        m_tuser
);
    import ttab_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    ttab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (ctl)
    );

    ttab_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctl),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // no beat is taken while the sweep is writing
    a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wipe |-> !s_tready)
        else $error("input accepted during table sweep");

    // bucket write-back never collides with a new read
    a_no_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> !ctl.load)
        else $error("bucket write in same cycle as input accept");

    // a clear reports both counters as zero
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.out_load && sts.item_cmd == CMD_CLEAR) |=> (m_tdata[89:26] == '0))
        else $error("counters not zero after clear");

endmodule
